// ===== rtl/bplt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplt_pkg
// Shared widths, register codes, trig constants and payload types for the
// body pose leg transform.
// ----------------------------------------------------------------------------
package bplt_pkg;

    localparam int ANG_W      = 16;
    localparam int OFS_W      = 11;
    localparam int PT_W       = 13;
    localparam int CRD_W      = 15;
    localparam int YAW_W      = 17;
    localparam int LEG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BODY_ROLL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_PITCH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_YAW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_OFFSET_Y = 3'd4;

    // Q13 radians
    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam int TWO_PI_Q13  = 51472;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Horner steps of the sine and cosine series, with floor(2^32 / k)
    localparam int HORNER_STEPS = 5;
    localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};
    localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
        32'(64'h1_0000_0000 / 64'd110), 32'(64'h1_0000_0000 / 64'd72),
        32'(64'h1_0000_0000 / 64'd42),  32'(64'h1_0000_0000 / 64'd20),
        32'(64'h1_0000_0000 / 64'd6)};
    localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
        32'(64'h1_0000_0000 / 64'd132), 32'(64'h1_0000_0000 / 64'd90),
        32'(64'h1_0000_0000 / 64'd56),  32'(64'h1_0000_0000 / 64'd30),
        32'(64'h1_0000_0000 / 64'd12)};

    typedef logic signed [YAW_W-1:0] angle_t;

    typedef struct packed {
        logic signed [CRD_W-1:0] tx;
        logic signed [CRD_W-1:0] ty;
        logic signed [CRD_W-1:0] pz;
    } coord_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] x;
        logic signed [OFS_W-1:0] y;
    } ofs_t;

    typedef struct packed {
        logic signed [LEG_W-1:0] x;
        logic signed [LEG_W-1:0] y;
        logic signed [LEG_W-1:0] z;
    } leg_t;

endpackage

// ===== rtl/bplt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplt_in_if
// Input channel: one leg endpoint, gait displacement and extra yaw per beat.
// ----------------------------------------------------------------------------
interface bplt_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bplt_pkg::PT_W-1:0]    point_x;
    logic signed [bplt_pkg::PT_W-1:0]    point_y;
    logic signed [bplt_pkg::PT_W-1:0]    point_z;
    logic signed [bplt_pkg::PT_W-1:0]    shift_x;
    logic signed [bplt_pkg::PT_W-1:0]    shift_y;
    logic signed [bplt_pkg::ANG_W-1:0]   extra_yaw;

    modport source (output valid, point_x, point_y, point_z, shift_x, shift_y, extra_yaw,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, shift_x, shift_y, extra_yaw,
                    output ready);
endinterface

// ===== rtl/bplt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplt_out_if
// Output channel: one corrected leg endpoint per beat.
// ----------------------------------------------------------------------------
interface bplt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bplt_pkg::LEG_W-1:0]   leg_x;
    logic signed [bplt_pkg::LEG_W-1:0]   leg_y;
    logic signed [bplt_pkg::LEG_W-1:0]   leg_z;

    modport source (output valid, leg_x, leg_y, leg_z, input ready);
    modport sink   (input valid, leg_x, leg_y, leg_z, output ready);
endinterface

// ===== rtl/bplt_horner_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplt_horner_step
// One Horner step t' = 1 - floor(((x2 * t) >> 30) / k) in Q30, three stages:
// product, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
module bplt_horner_step #(
    parameter logic [7:0]  DIV = 8'd110,
    parameter logic [31:0] RCP = 32'd39045157
) (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] x2,
    input  logic [30:0] t_in,
    output logic [30:0] t_out
);

    logic [62:0] prod_a;
    logic [63:0] prod_b;
    logic [39:0] qk;
    logic [31:0] rem;
    logic [31:0] q_fix;
    logic [30:0] t_next;

    logic [31:0] v_a_reg;
    logic [31:0] v_b_reg;
    logic [31:0] q_b_reg;
    logic [30:0] t_reg;

    always_comb
    begin
        prod_a = x2 * t_in;
        prod_b = v_a_reg * RCP;
        qk     = q_b_reg * DIV;
        rem    = v_b_reg - qk[31:0];
        // estimate is low by at most one
        q_fix  = (rem >= 32'(DIV)) ? q_b_reg + 32'd1 : q_b_reg;
        t_next = bplt_pkg::Q30_ONE - q_fix[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_a_reg <= prod_a[61:30];
            v_b_reg <= v_a_reg;
            q_b_reg <= prod_b[63:32];
            t_reg   <= t_next;
        end
    end

    assign t_out = t_reg;

endmodule

// ===== rtl/bplt_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplt_sincos
// Pipelined sine and cosine of a Q13 angle, 20 stages: reduce, fold, square,
// five Horner steps per series, final product, clamp and round.
// ----------------------------------------------------------------------------
module bplt_sincos #(
    parameter int FRAC_BITS = 15
) (
    input  logic                        clk,
    input  logic                        en,
    input  bplt_pkg::angle_t            ang,
    output logic signed [FRAC_BITS+1:0] sin_q,
    output logic signed [FRAC_BITS+1:0] cos_q
);

    localparam int SW = FRAC_BITS + 2;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic [31:0] RND = 32'((64'd1 << SH) >> 1);
    localparam int NS = bplt_pkg::HORNER_STEPS;
    localparam int LAST = 2 + 3 * NS;

    localparam logic signed [17:0] PI18   = 18'(bplt_pkg::PI_Q13);
    localparam logic signed [17:0] TWOPI18 = 18'(bplt_pkg::TWO_PI_Q13);
    localparam logic [14:0] PI15   = 15'(bplt_pkg::PI_Q13);
    localparam logic [14:0] HALF15 = 15'(bplt_pkg::HALF_PI_Q13);

    typedef struct packed {
        logic sneg;
        logic cneg;
    } fold_t;

    logic signed [17:0] a18;
    logic signed [17:0] r18;
    logic [15:0]        mag16;
    logic [14:0]        mag;
    fold_t              fold_next;
    logic [30:0]        x_next;
    logic [61:0]        xx;
    logic [61:0]        sp;
    logic [62:0]        cp;
    logic [30:0]        svc;
    logic [30:0]        cv;
    logic [31:0]        s_rnd;
    logic [31:0]        c_rnd;
    logic signed [SW-1:0] s_mag;
    logic signed [SW-1:0] c_mag;

    logic signed [15:0] r_reg;
    logic [30:0]        x_line  [1:LAST];
    logic [31:0]        x2_line [2:LAST];
    fold_t              fold_line [1:LAST+1];
    logic [30:0]        ts [NS+1];
    logic [30:0]        tc [NS+1];
    logic [31:0]        sv_reg;
    logic [30:0]        u_reg;
    logic signed [SW-1:0] sin_reg;
    logic signed [SW-1:0] cos_reg;

    always_comb
    begin
        // reduce into [-pi, pi)
        a18 = 18'(ang);
        if (a18 >= PI18)
            r18 = a18 - TWOPI18;
        else if (a18 < -PI18)
            r18 = a18 + TWOPI18;
        else
            r18 = a18;

        // fold into [0, pi/2]
        fold_next.sneg = r_reg[15];
        mag16 = r_reg[15] ? -r_reg : r_reg;
        mag = mag16[14:0];
        fold_next.cneg = 1'b0;
        if (mag > HALF15)
        begin
            mag = PI15 - mag;
            fold_next.cneg = 1'b1;
        end
        x_next = {mag[13:0], 17'd0};

        xx = x_line[1] * x_line[1];
        sp = x_line[LAST] * ts[NS];
        cp = x2_line[LAST] * tc[NS];

        svc = (sv_reg > 32'(bplt_pkg::Q30_ONE)) ? bplt_pkg::Q30_ONE : sv_reg[30:0];
        cv  = (u_reg >= bplt_pkg::Q30_ONE) ? 31'd0 : bplt_pkg::Q30_ONE - u_reg;
        s_rnd = ({1'b0, svc} + RND) >> SH;
        c_rnd = ({1'b0, cv} + RND) >> SH;
        s_mag = SW'({1'b0, s_rnd[FRAC_BITS:0]});
        c_mag = SW'({1'b0, c_rnd[FRAC_BITS:0]});
    end

    assign ts[0] = bplt_pkg::Q30_ONE;
    assign tc[0] = bplt_pkg::Q30_ONE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg        <= r18[15:0];
            x_line[1]    <= x_next;
            fold_line[1] <= fold_next;
            x2_line[2]   <= xx[61:30];
            sv_reg       <= sp[61:30];
            u_reg        <= cp[61:31];
            sin_reg      <= fold_line[LAST+1].sneg ? -s_mag : s_mag;
            cos_reg      <= fold_line[LAST+1].cneg ? -c_mag : c_mag;
        end
    end

    for (genvar k = 2; k <= LAST; k++)
    begin : g_x_line
        always_ff @(posedge clk)
        begin
            if (en)
                x_line[k] <= x_line[k-1];
        end
    end

    for (genvar k = 3; k <= LAST; k++)
    begin : g_x2_line
        always_ff @(posedge clk)
        begin
            if (en)
                x2_line[k] <= x2_line[k-1];
        end
    end

    for (genvar k = 2; k <= LAST + 1; k++)
    begin : g_fold_line
        always_ff @(posedge clk)
        begin
            if (en)
                fold_line[k] <= fold_line[k-1];
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_step
        bplt_horner_step #(
            .DIV (bplt_pkg::SIN_DIV[i]),
            .RCP (bplt_pkg::SIN_RCP[i])
        ) u_sin_step (
            .clk   (clk),
            .en    (en),
            .x2    (x2_line[2 + 3 * i]),
            .t_in  (ts[i]),
            .t_out (ts[i+1])
        );

        bplt_horner_step #(
            .DIV (bplt_pkg::COS_DIV[i]),
            .RCP (bplt_pkg::COS_RCP[i])
        ) u_cos_step (
            .clk   (clk),
            .en    (en),
            .x2    (x2_line[2 + 3 * i]),
            .t_in  (tc[i]),
            .t_out (tc[i+1])
        );
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ===== rtl/bplt_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bplt_rotate
// Builds the roll-pitch-yaw matrix, rotates the shifted point and forms the
// saturated leg correction. Six stages.
// ----------------------------------------------------------------------------
module bplt_rotate #(
    parameter int FRAC_BITS = 15
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [FRAC_BITS+1:0] sb,
    input  logic signed [FRAC_BITS+1:0] cb,
    input  logic signed [FRAC_BITS+1:0] sg,
    input  logic signed [FRAC_BITS+1:0] cg,
    input  logic signed [FRAC_BITS+1:0] sa,
    input  logic signed [FRAC_BITS+1:0] ca,
    input  bplt_pkg::coord_t            crd,
    input  bplt_pkg::ofs_t              ofs,
    output bplt_pkg::leg_t              leg_pt
);

    localparam int SW  = FRAC_BITS + 2;
    localparam int P2W = 2 * SW;
    localparam int MW  = SW + 1;
    localparam int PW  = bplt_pkg::CRD_W + MW;
    localparam int RW  = PW + 2;
    localparam int OW  = RW + 1;
    localparam int LW  = bplt_pkg::LEG_W;
    localparam logic signed [P2W-1:0] BIAS_P = P2W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [RW-1:0]  BIAS_R = RW'((64'd1 << FRAC_BITS) - 64'd1);

    // products of two Q(F) factors, back to Q(F), truncated toward zero
    function automatic logic signed [SW-1:0] tz_p(input logic signed [P2W-1:0] p);
        logic signed [P2W-1:0] b;
        b = p + (p[P2W-1] ? BIAS_P : P2W'(0));
        return SW'(b >>> FRAC_BITS);
    endfunction

    function automatic logic signed [RW-1:0] tz_r(input logic signed [RW-1:0] s);
        logic signed [RW-1:0] b;
        b = s + (s[RW-1] ? BIAS_R : RW'(0));
        return b >>> FRAC_BITS;
    endfunction

    function automatic logic signed [LW-1:0] sat(input logic signed [OW-1:0] v);
        logic ovf;
        ovf = (v[OW-1:LW-1] != {(OW-LW+1){1'b0}}) && (v[OW-1:LW-1] != {(OW-LW+1){1'b1}});
        if (ovf)
            return v[OW-1] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
        return v[LW-1:0];
    endfunction

    // stage 1: two-factor products
    logic signed [P2W-1:0] p_sbsg_reg, p_cbsg_reg, p_cgca_reg, p_cbsa_reg, p_sbsa_reg;
    logic signed [P2W-1:0] p_cgsa_reg, p_cbca_reg, p_sbca_reg, p_sbcg_reg, p_cbcg_reg;
    logic signed [SW-1:0]  sa1_reg, ca1_reg, sg1_reg;
    // stage 2: three-factor products and truncated terms
    logic signed [SW-1:0]  sbsg_t, cbsg_t;
    logic signed [P2W-1:0] q_sbsgca_reg, q_cbsgca_reg, q_sbsgsa_reg, q_cbsgsa_reg;
    logic signed [SW-1:0]  cgca2_reg, cbsa2_reg, sbsa2_reg, cgsa2_reg, cbca2_reg;
    logic signed [SW-1:0]  sbca2_reg, sbcg2_reg, cbcg2_reg, nsg2_reg;
    // stage 3: matrix
    logic signed [MW-1:0]  m00_reg, m01_reg, m02_reg, m10_reg, m11_reg, m12_reg;
    logic signed [MW-1:0]  m20_reg, m21_reg, m22_reg;
    // stage 4: coordinate products
    logic signed [PW-1:0]  r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg;
    logic signed [PW-1:0]  r20_reg, r21_reg, r22_reg;
    // stage 5: rotated point
    logic signed [RW-1:0]  rx_next, ry_next, rz_next;
    logic signed [RW-1:0]  rx_reg, ry_reg, rz_reg;
    // stage 6: output
    logic signed [OW-1:0]  fx, fy, fz;
    bplt_pkg::leg_t        leg_reg;

    bplt_pkg::coord_t      crd_line [1:5];

    always_comb
    begin
        sbsg_t = tz_p(p_sbsg_reg);
        cbsg_t = tz_p(p_cbsg_reg);

        rx_next = tz_r(RW'(r00_reg) + RW'(r01_reg) + RW'(r02_reg));
        ry_next = tz_r(RW'(r10_reg) + RW'(r11_reg) + RW'(r12_reg));
        rz_next = tz_r(RW'(r20_reg) + RW'(r21_reg) + RW'(r22_reg));

        fx = OW'(crd_line[5].tx) - OW'(rx_reg) + OW'(ofs.x);
        fy = OW'(crd_line[5].ty) - OW'(ry_reg) + OW'(ofs.y);
        fz = OW'(crd_line[5].pz) - OW'(rz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sbsg_reg <= sb * sg;
            p_cbsg_reg <= cb * sg;
            p_cgca_reg <= cg * ca;
            p_cbsa_reg <= cb * sa;
            p_sbsa_reg <= sb * sa;
            p_cgsa_reg <= cg * sa;
            p_cbca_reg <= cb * ca;
            p_sbca_reg <= sb * ca;
            p_sbcg_reg <= sb * cg;
            p_cbcg_reg <= cb * cg;
            sa1_reg    <= sa;
            ca1_reg    <= ca;
            sg1_reg    <= sg;
            crd_line[1] <= crd;

            q_sbsgca_reg <= sbsg_t * ca1_reg;
            q_cbsgca_reg <= cbsg_t * ca1_reg;
            q_sbsgsa_reg <= sbsg_t * sa1_reg;
            q_cbsgsa_reg <= cbsg_t * sa1_reg;
            cgca2_reg <= tz_p(p_cgca_reg);
            cbsa2_reg <= tz_p(p_cbsa_reg);
            sbsa2_reg <= tz_p(p_sbsa_reg);
            cgsa2_reg <= tz_p(p_cgsa_reg);
            cbca2_reg <= tz_p(p_cbca_reg);
            sbca2_reg <= tz_p(p_sbca_reg);
            sbcg2_reg <= tz_p(p_sbcg_reg);
            cbcg2_reg <= tz_p(p_cbcg_reg);
            nsg2_reg  <= -sg1_reg;
            crd_line[2] <= crd_line[1];

            m00_reg <= MW'(cgca2_reg);
            m01_reg <= MW'(tz_p(q_sbsgca_reg)) - MW'(cbsa2_reg);
            m02_reg <= MW'(tz_p(q_cbsgca_reg)) + MW'(sbsa2_reg);
            m10_reg <= MW'(cgsa2_reg);
            m11_reg <= MW'(tz_p(q_sbsgsa_reg)) + MW'(cbca2_reg);
            m12_reg <= MW'(tz_p(q_cbsgsa_reg)) - MW'(sbca2_reg);
            m20_reg <= MW'(nsg2_reg);
            m21_reg <= MW'(sbcg2_reg);
            m22_reg <= MW'(cbcg2_reg);
            crd_line[3] <= crd_line[2];

            r00_reg <= crd_line[3].tx * m00_reg;
            r01_reg <= crd_line[3].ty * m01_reg;
            r02_reg <= crd_line[3].pz * m02_reg;
            r10_reg <= crd_line[3].tx * m10_reg;
            r11_reg <= crd_line[3].ty * m11_reg;
            r12_reg <= crd_line[3].pz * m12_reg;
            r20_reg <= crd_line[3].tx * m20_reg;
            r21_reg <= crd_line[3].ty * m21_reg;
            r22_reg <= crd_line[3].pz * m22_reg;
            crd_line[4] <= crd_line[3];

            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
            crd_line[5] <= crd_line[4];

            leg_reg.x <= sat(fx);
            leg_reg.y <= sat(fy);
            leg_reg.z <= sat(fz);
        end
    end

    assign leg_pt = leg_reg;

endmodule

// ===== rtl/body_pose_leg_transform_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_pose_leg_transform_top
// Shifts a leg endpoint by gait and body offset, rotates it by the body
// roll-pitch-yaw and returns the saturated leg correction.
// ----------------------------------------------------------------------------
// Usage:
//   point : valid/ready input channel, one endpoint, gait shift and extra yaw
//           per beat. leg : valid/ready output channel, one result per beat.
//   cfg_we/cfg_idx/cfg_data write body roll, pitch, yaw (indices 0..2) and
//   body offset x/y (3..4); other indices are ignored. Write only while no
//   beat is in flight.
//   Throughput: one beat per cycle while the skid register is empty. Three
//   sine/cosine pipelines (one each for roll, pitch and yaw) and the
//   matrix/rotation pipeline are fully pipelined. An accepted point passes
//   through 1 capture stage, 20 trig stages, 6 rotation stages and output reg.
//   Reset clears the configuration registers to zero and empties the pipeline.
//   A stalled receiver holds the output register; one more result lands in a
//   skid register, then ready drops and the whole pipeline freezes without
//   losing or repeating a beat.
// ----------------------------------------------------------------------------
module body_pose_leg_transform_top #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bplt_in_if.sink                              point,
    bplt_out_if.source                           leg,
    input  logic                                 cfg_we,
    input  logic [bplt_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [bplt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW     = TRIG_FRAC_BITS + 2;
    localparam int NSTG   = 27;
    localparam int TRIG_O = 20;
    localparam int CW     = bplt_pkg::CRD_W;
    localparam int YW     = bplt_pkg::YAW_W;

    logic signed [bplt_pkg::ANG_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [bplt_pkg::OFS_W-1:0] ofs_x_reg, ofs_y_reg;
    bplt_pkg::ofs_t ofs;

    logic en;
    logic take;
    logic [NSTG-1:0] vld_reg;

    bplt_pkg::coord_t crd_next;
    bplt_pkg::coord_t crd_line [0:TRIG_O];
    bplt_pkg::angle_t roll_ang_reg, pitch_ang_reg, yaw_ang_reg;

    logic signed [SW-1:0] sb, cb, sg, cg, sa, ca;
    bplt_pkg::leg_t pipe_leg;
    bplt_pkg::leg_t o_data_reg, s_data_reg;
    logic o_vld_reg, s_vld_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            ofs_x_reg <= '0;
            ofs_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                bplt_pkg::REG_BODY_ROLL:     roll_reg  <= cfg_data;
                bplt_pkg::REG_BODY_PITCH:    pitch_reg <= cfg_data;
                bplt_pkg::REG_BODY_YAW:      yaw_reg   <= cfg_data;
                bplt_pkg::REG_BODY_OFFSET_X: ofs_x_reg <= cfg_data[bplt_pkg::OFS_W-1:0];
                bplt_pkg::REG_BODY_OFFSET_Y: ofs_y_reg <= cfg_data[bplt_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    assign ofs.x = ofs_x_reg;
    assign ofs.y = ofs_y_reg;

    // whole pipeline moves together; it stops only when the skid is full
    assign en          = ~s_vld_reg;
    assign point.ready = en;
    assign take        = en & vld_reg[NSTG-1];

    always_comb
    begin
        crd_next.tx = CW'(point.point_x) + CW'(point.shift_x) + CW'(ofs_x_reg);
        crd_next.ty = CW'(point.point_y) + CW'(point.shift_y) + CW'(ofs_y_reg);
        crd_next.pz = CW'(point.point_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], point.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crd_line[0]   <= crd_next;
            roll_ang_reg  <= YW'(roll_reg);
            pitch_ang_reg <= YW'(pitch_reg);
            yaw_ang_reg   <= YW'(yaw_reg) + YW'(point.extra_yaw);
        end
    end

    for (genvar k = 1; k <= TRIG_O; k++)
    begin : g_crd_line
        always_ff @(posedge clk)
        begin
            if (en)
                crd_line[k] <= crd_line[k-1];
        end
    end

    bplt_sincos #(.FRAC_BITS(TRIG_FRAC_BITS)) u_roll (
        .clk   (clk),
        .en    (en),
        .ang   (roll_ang_reg),
        .sin_q (sb),
        .cos_q (cb)
    );

    bplt_sincos #(.FRAC_BITS(TRIG_FRAC_BITS)) u_pitch (
        .clk   (clk),
        .en    (en),
        .ang   (pitch_ang_reg),
        .sin_q (sg),
        .cos_q (cg)
    );

    bplt_sincos #(.FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
        .clk   (clk),
        .en    (en),
        .ang   (yaw_ang_reg),
        .sin_q (sa),
        .cos_q (ca)
    );

    bplt_rotate #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rotate (
        .clk    (clk),
        .en     (en),
        .sb     (sb),
        .cb     (cb),
        .sg     (sg),
        .cg     (cg),
        .sa     (sa),
        .ca     (ca),
        .crd    (crd_line[TRIG_O]),
        .ofs    (ofs),
        .leg_pt (pipe_leg)
    );

    // output register plus skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else if (o_vld_reg && !leg.ready)
        begin
            if (take)
                s_vld_reg <= 1'b1;
        end
        else if (s_vld_reg)
        begin
            o_vld_reg <= 1'b1;
            s_vld_reg <= 1'b0;
        end
        else
        begin
            o_vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_vld_reg && !leg.ready)
        begin
            if (take)
                s_data_reg <= pipe_leg;
        end
        else if (s_vld_reg)
        begin
            o_data_reg <= s_data_reg;
        end
        else if (take)
        begin
            o_data_reg <= pipe_leg;
        end
    end

    assign leg.valid = o_vld_reg;
    assign leg.leg_x = o_data_reg.x;
    assign leg.leg_y = o_data_reg.y;
    assign leg.leg_z = o_data_reg.z;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_vld_reg |-> o_vld_reg)
        else $error("skid holds a beat while output register is empty");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        o_vld_reg && !leg.ready && take |=> s_vld_reg)
        else $error("beat leaving the pipeline was not caught by the skid");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_vld_reg) |-> $past(vld_reg[NSTG-1] && en))
        else $error("output became valid without a beat from the pipeline");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> vld_reg[0])
        else $error("accepted beat did not enter the capture stage");
`endif

endmodule

// ===== verif/body_pose_leg_transform_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_pose_leg_transform_checker
// Watches the point and leg channels and the register port. It models the
// Q13 angle reduction, series trig and the roll-pitch-yaw rotation, and
// compares every leg beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module body_pose_leg_transform_checker #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bplt_in_if                                   point,
    bplt_out_if                                  leg,
    input  logic                                 cfg_we,
    input  logic [bplt_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [bplt_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   errors,
    output int                                   inflight
);

    localparam int ANG_W = bplt_pkg::ANG_W;
    localparam int OFS_W = bplt_pkg::OFS_W;
    localparam int LEG_W = bplt_pkg::LEG_W;

    localparam longint unsigned ONE30 = 64'd1 << 30;
    localparam longint unsigned SIN_K [5] = '{110, 72, 42, 20, 6};
    localparam longint unsigned COS_K [5] = '{132, 90, 56, 30, 12};

    logic signed [ANG_W-1:0] roll, pitch, yaw;
    logic signed [OFS_W-1:0] ofs_x, ofs_y;
    bplt_pkg::leg_t          leg_q[$];

    function automatic longint q30_to_frac(input longint unsigned v);
        int sh;
        sh = 30 - TRIG_FRAC_BITS;
        return longint'((v + ((64'd1 << sh) >> 1)) >> sh);
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        longint          r;
        bit              sneg, cneg;
        longint unsigned a, x, x2, t, sv, cv, u;
        r = ang % bplt_pkg::TWO_PI_Q13;
        if (r < 0)
            r += bplt_pkg::TWO_PI_Q13;
        if (r >= bplt_pkg::PI_Q13)
            r -= bplt_pkg::TWO_PI_Q13;
        sneg = r < 0;
        cneg = 1'b0;
        a = sneg ? longint'(-r) : longint'(r);
        if (a > bplt_pkg::HALF_PI_Q13)
        begin
            a = bplt_pkg::PI_Q13 - a;
            cneg = 1'b1;
        end
        x  = a << 17;
        x2 = (x * x) >> 30;
        t = ONE30;
        for (int i = 0; i < 5; i++)
            t = ONE30 - ((x2 * t) >> 30) / SIN_K[i];
        sv = (x * t) >> 30;
        if (sv > ONE30)
            sv = ONE30;
        t = ONE30;
        for (int i = 0; i < 5; i++)
            t = ONE30 - ((x2 * t) >> 30) / COS_K[i];
        u  = ((x2 * t) >> 30) / 2;
        cv = (u >= ONE30) ? 64'd0 : ONE30 - u;
        s = sneg ? -q30_to_frac(sv) : q30_to_frac(sv);
        c = cneg ? -q30_to_frac(cv) : q30_to_frac(cv);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) / (longint'(1) << TRIG_FRAC_BITS);
    endfunction

    function automatic logic signed [LEG_W-1:0] clip16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[LEG_W-1:0];
    endfunction

    function automatic bplt_pkg::leg_t leg_correction(input longint px, py, pz, dx, dy, ey);
        longint sb, cb, sg, cg, sa, ca, ox, oy, tx, ty, sbsg, cbsg, one;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22, rx, ry, rz;
        bplt_pkg::leg_t res;
        ox = ofs_x;
        oy = ofs_y;
        one = longint'(1) << TRIG_FRAC_BITS;
        sin_cos(roll, sb, cb);
        sin_cos(pitch, sg, cg);
        sin_cos(longint'(yaw) + ey, sa, ca);
        tx = px + dx + ox;
        ty = py + dy + oy;
        sbsg = qmul(sb, sg);
        cbsg = qmul(cb, sg);
        m00 = qmul(cg, ca);
        m01 = qmul(sbsg, ca) - qmul(cb, sa);
        m02 = qmul(cbsg, ca) + qmul(sb, sa);
        m10 = qmul(cg, sa);
        m11 = qmul(sbsg, sa) + qmul(cb, ca);
        m12 = qmul(cbsg, sa) - qmul(sb, ca);
        m20 = -sg;
        m21 = qmul(sb, cg);
        m22 = qmul(cb, cg);
        rx = (tx * m00 + ty * m01 + pz * m02) / one;
        ry = (tx * m10 + ty * m11 + pz * m12) / one;
        rz = (tx * m20 + ty * m21 + pz * m22) / one;
        res.x = clip16(tx - rx + ox);
        res.y = clip16(ty - ry + oy);
        res.z = clip16(pz - rz);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bplt_pkg::leg_t got, want;
        if (!rst_n)
        begin
            roll <= '0;
            pitch <= '0;
            yaw <= '0;
            ofs_x <= '0;
            ofs_y <= '0;
            leg_q.delete();
            errors <= 0;
            inflight <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    bplt_pkg::REG_BODY_ROLL:     roll  <= cfg_data;
                    bplt_pkg::REG_BODY_PITCH:    pitch <= cfg_data;
                    bplt_pkg::REG_BODY_YAW:      yaw   <= cfg_data;
                    bplt_pkg::REG_BODY_OFFSET_X: ofs_x <= cfg_data[OFS_W-1:0];
                    bplt_pkg::REG_BODY_OFFSET_Y: ofs_y <= cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (point.valid && point.ready)
                leg_q.push_back(leg_correction(point.point_x, point.point_y, point.point_z,
                                               point.shift_x, point.shift_y,
                                               point.extra_yaw));
            if (leg.valid && leg.ready)
            begin
                got.x = leg.leg_x;
                got.y = leg.leg_y;
                got.z = leg.leg_z;
                if (leg_q.size() == 0)
                begin
                    $display("%0t: unexpected leg beat x=%0d y=%0d z=%0d",
                             $time, got.x, got.y, got.z);
                    errors <= errors + 1;
                end
                else
                begin
                    want = leg_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z)
                    begin
                        $display("%0t: leg mismatch expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 $time, want.x, want.y, want.z, got.x, got.y, got.z);
                        errors <= errors + 1;
                    end
                end
            end
            inflight <= leg_q.size();
        end
    end

    final
    begin
    end
endmodule

// ===== verif/body_pose_leg_transform_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_pose_leg_transform_top_tb
// Directed and random leg endpoints under several body poses, with random
// idling on both channels; the checker predicts and compares each beat.
// ----------------------------------------------------------------------------
module body_pose_leg_transform_top_tb;

    localparam int PT_W       = bplt_pkg::PT_W;
    localparam int ANG_W      = bplt_pkg::ANG_W;
    localparam int CFG_IDX_W  = bplt_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bplt_pkg::CFG_DATA_W;

    // indices with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic signed [PT_W-1:0]  CRD_MAX  = 13'sd4095;
    localparam logic signed [PT_W-1:0]  CRD_MIN  = 13'sh1000;
    localparam logic signed [PT_W-1:0]  CRD_ZERO = 13'sd0;
    localparam logic signed [ANG_W-1:0] ANG_ZERO = 16'sd0;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  no_idle;
    int                    errors;
    int                    inflight;

    bplt_in_if  point_ch ();
    bplt_out_if leg_ch ();

    body_pose_leg_transform_top #(.TRIG_FRAC_BITS(15)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point_ch),
        .leg      (leg_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    body_pose_leg_transform_checker #(.TRIG_FRAC_BITS(15)) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .point    (point_ch),
        .leg      (leg_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .errors   (errors),
        .inflight (inflight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("body_pose_leg_transform_top test failed");
        $finish;
    end

    // leg side backpressure
    always @(posedge clk)
        leg_ch.ready <= no_idle || ($urandom_range(0, 99) >= 33);

    function automatic logic signed [PT_W-1:0] pick_crd();
        case ($urandom_range(0, 9))
            0: return CRD_MIN;
            1: return CRD_MAX;
            2: return PT_W'($urandom_range(0, 200)) - 13'sd100;
            default: return PT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ANG_W-1:0] pick_ang();
        case ($urandom_range(0, 11))
            0: return 16'sd25736;
            1: return -16'sd25736;
            2: return 16'sd12868;
            3: return -16'sd12868;
            4: return 16'sh7fff;
            5: return 16'sh8000;
            6: return 16'sd0;
            default: return ANG_W'($urandom);
        endcase
    endfunction

    task automatic send_point(input logic signed [PT_W-1:0] px, py, pz, sx, sy,
                              input logic signed [ANG_W-1:0] ey);
        while (!no_idle && $urandom_range(0, 99) < 33)
        begin
            point_ch.valid <= 1'b0;
            @(posedge clk);
        end
        point_ch.valid     <= 1'b1;
        point_ch.point_x   <= px;
        point_ch.point_y   <= py;
        point_ch.point_z   <= pz;
        point_ch.shift_x   <= sx;
        point_ch.shift_y   <= sy;
        point_ch.extra_yaw <= ey;
        do
            @(posedge clk);
        while (!point_ch.ready);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // registers only move once the pipeline is empty
    task automatic set_pose(input logic [CFG_DATA_W-1:0] r, p, y, ox, oy);
        point_ch.valid <= 1'b0;
        repeat (40) @(posedge clk);
        while (inflight != 0)
            @(posedge clk);
        reg_write(bplt_pkg::REG_BODY_ROLL, r);
        reg_write(bplt_pkg::REG_BODY_PITCH, p);
        reg_write(bplt_pkg::REG_BODY_YAW, y);
        reg_write(bplt_pkg::REG_BODY_OFFSET_X, ox);
        reg_write(bplt_pkg::REG_BODY_OFFSET_Y, oy);
        reg_write(REG_UNMAPPED_LO, 16'hffff);
        reg_write(REG_UNMAPPED_HI, 16'h1234);
        cfg_we <= 1'b0;
    endtask

    task automatic random_points(input int n);
        for (int i = 0; i < n; i++)
            send_point(pick_crd(), pick_crd(), pick_crd(), pick_crd(), pick_crd(), pick_ang());
    endtask

    initial
    begin
        int cycles;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        no_idle            = 1'b0;
        point_ch.valid     = 1'b0;
        point_ch.point_x   = '0;
        point_ch.point_y   = '0;
        point_ch.point_z   = '0;
        point_ch.shift_x   = '0;
        point_ch.shift_y   = '0;
        point_ch.extra_yaw = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity pose, then field extremes and wrapped angles
        send_point(CRD_ZERO, CRD_ZERO, CRD_ZERO, CRD_ZERO, CRD_ZERO, ANG_ZERO);
        send_point(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, ANG_ZERO);
        send_point(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, ANG_ZERO);
        send_point(13'sd100, -13'sd200, 13'sd300, CRD_ZERO, CRD_ZERO, 16'sd25736);
        send_point(13'sd100, -13'sd200, 13'sd300, CRD_ZERO, CRD_ZERO, -16'sd25736);
        send_point(13'sd100, -13'sd200, 13'sd300, CRD_ZERO, CRD_ZERO, 16'sd12868);
        send_point(13'sd100, -13'sd200, 13'sd300, CRD_ZERO, CRD_ZERO, 16'sh7fff);
        send_point(13'sd100, -13'sd200, 13'sd300, CRD_ZERO, CRD_ZERO, 16'sh8000);
        set_pose(16'd25736, 16'd25736, 16'd25736, 16'd1023, 16'd1023);
        send_point(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, 16'sd25736);
        send_point(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, 16'sd25736);
        send_point(CRD_MAX, CRD_MIN, CRD_MAX, CRD_MIN, CRD_MAX, -16'sd12868);
        send_point(13'sd1, 13'sd1, 13'sd1, 13'sd1, 13'sd1, 16'sd6434);
        set_pose(-16'sd25736, -16'sd25736, 16'sh8000, -16'sd1024, -16'sd1024);
        send_point(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, 16'sh8000);
        send_point(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, 16'sh8000);
        send_point(CRD_MIN, CRD_MAX, CRD_MIN, CRD_MAX, CRD_MIN, 16'sd12868);
        set_pose(16'sh7fff, 16'sh8000, 16'sd12868, 16'sd1023, -16'sd1024);
        send_point(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX, 16'sh7fff);
        send_point(CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, CRD_MIN, -16'sd12868);
        send_point(CRD_ZERO, CRD_ZERO, CRD_MAX, CRD_ZERO, CRD_ZERO, ANG_ZERO);

        random_points(300);
        set_pose(16'd2000, -16'sd3000, 16'd4000, 16'd100, -16'sd50);
        no_idle = 1'b1;
        random_points(300);
        no_idle = 1'b0;
        set_pose(16'sd25736, 16'sd12868, -16'sd12868, -16'sd1024, 16'sd1023);
        random_points(300);
        for (int k = 0; k < 3; k++)
        begin
            set_pose(pick_ang(), pick_ang(), pick_ang(), 16'($urandom), 16'($urandom));
            random_points(300);
        end
        point_ch.valid <= 1'b0;

        cycles = 0;
        while (inflight != 0 && cycles < 100000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (60) @(posedge clk);
        if (errors == 0 && inflight == 0)
            $display("body_pose_leg_transform_top test passed");
        else
            $display("body_pose_leg_transform_top test failed");
        $finish;
    end
endmodule
